/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files that check their own behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define DASD_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("dasd assertion failed");

// consequent must hold at the same edge as the antecedent
`define DASD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dasd assertion failed");

// consequent must hold at the next edge after the antecedent
`define DASD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dasd assertion failed");

`endif

/* hw/rtl/dasd_pkg.sv */
// shared types, constants and calendar functions of the date offset block
package dasd_pkg;

	// defaults of the top level parameters
	localparam int YEAR_MAX_DEF    = 9999;
	localparam int OFFSET_BITS_DEF = 20;

	// fixed field widths
	localparam int DAY_W      = 5;
	localparam int MONTH_W    = 4;
	localparam int YEAR_IN_W  = 14;
	localparam int STATUS_W   = 2;
	localparam int YEAR_IN_MAX = (1 << YEAR_IN_W) - 1;

	// leap cycle of the gregorian calendar
	localparam int CYCLE_YEARS = 400;
	localparam int CYCLE_W     = 9;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_DATE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

	// month numbers
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_DOY,
		ST_APPLY,
		ST_YEAR,
		ST_MONTH,
		ST_FINISH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic mod_step;
		logic flag_invalid;
		logic doy_step;
		logic apply;
		logic year_step;
		logic flag_range;
		logic month_init;
		logic month_step;
		logic publish;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic mod_ge_cycle;
		logic date_bad;
		logic doy_more;
		logic year_more;
		logic year_err;
		logic month_more;
	} stat_t;

	// leap test on the year position within the 400 year cycle
	function automatic logic leap_of(input logic [CYCLE_W-1:0] c);
		return (c[1:0] == 2'd0) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
	endfunction

	// days in a month, anything outside the short months counts 31
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* hw/rtl/dasd_req_if.sv */
// request channel: start date, offset and direction
interface dasd_req_if #(
	parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [dasd_pkg::DAY_W-1:0]        start_day;
	logic [dasd_pkg::MONTH_W-1:0]      start_month;
	logic [dasd_pkg::YEAR_IN_W-1:0]    start_year;
	logic [OFFSET_BITS-1:0]            offset_days;

	modport source (
		output valid, req_type, start_day, start_month, start_year, offset_days,
		input  ready
	);

	modport sink (
		input  valid, req_type, start_day, start_month, start_year, offset_days,
		output ready
	);
endinterface

/* hw/rtl/dasd_rsp_if.sv */
// response channel: resulting date and status
interface dasd_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [dasd_pkg::DAY_W-1:0]        result_day;
	logic [dasd_pkg::MONTH_W-1:0]      result_month;
	logic [dasd_pkg::YEAR_IN_W-1:0]    result_year;
	logic [dasd_pkg::STATUS_W-1:0]     status;

	modport source (
		output valid, result_day, result_month, result_year, status,
		input  ready
	);

	modport sink (
		input  valid, result_day, result_month, result_year, status,
		output ready
	);
endinterface

/* hw/rtl/dasd_datapath.sv */
// datapath: date registers, year and month walkers, result register
module dasd_datapath #(
	parameter int YEAR_MAX    = dasd_pkg::YEAR_MAX_DEF,
	parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  dasd_pkg::cmd_t                  cmd,
	output dasd_pkg::stat_t                 stat,
	input  logic                            req_type,
	input  logic [dasd_pkg::DAY_W-1:0]      start_day,
	input  logic [dasd_pkg::MONTH_W-1:0]    start_month,
	input  logic [dasd_pkg::YEAR_IN_W-1:0]  start_year,
	input  logic [OFFSET_BITS-1:0]          offset_days,
	output logic [dasd_pkg::DAY_W-1:0]      result_day,
	output logic [dasd_pkg::MONTH_W-1:0]    result_month,
	output logic [dasd_pkg::YEAR_IN_W-1:0]  result_year,
	output logic [dasd_pkg::STATUS_W-1:0]   status
);
	localparam int YEAR_CAP = (YEAR_MAX > dasd_pkg::YEAR_IN_MAX) ? YEAR_MAX
		: dasd_pkg::YEAR_IN_MAX;
	localparam int YW = $clog2(YEAR_CAP + 1);
	localparam int TW = OFFSET_BITS + 2;
	localparam int MW = dasd_pkg::YEAR_IN_W;

	localparam logic [YW-1:0] YEAR_LAST  = YW'(YEAR_MAX);
	localparam logic [MW-1:0] CYCLE      = MW'(dasd_pkg::CYCLE_YEARS);
	localparam logic [MW-1:0] CYCLE_LAST = MW'(dasd_pkg::CYCLE_YEARS - 1);

	// captured request
	logic                             sub_q;
	logic [dasd_pkg::DAY_W-1:0]       sday_q;
	logic [dasd_pkg::MONTH_W-1:0]     smon_q;
	logic [dasd_pkg::YEAR_IN_W-1:0]   syear_q;
	logic [OFFSET_BITS-1:0]           off_q;

	// working state
	logic [YW-1:0]                    ry_q;
	logic [MW-1:0]                    mod_q;
	logic signed [TW-1:0]             t_q;
	logic [dasd_pkg::MONTH_W-1:0]     mo_q;
	logic [dasd_pkg::STATUS_W-1:0]    st_q;

	// result register
	logic [dasd_pkg::DAY_W-1:0]       res_day_q;
	logic [dasd_pkg::MONTH_W-1:0]     res_mon_q;
	logic [dasd_pkg::YEAR_IN_W-1:0]   res_year_q;
	logic [dasd_pkg::STATUS_W-1:0]    res_st_q;

	logic [MW-1:0]                    mod_inc;
	logic [MW-1:0]                    mod_dec;
	logic                             leap_cur;
	logic                             leap_prev;
	logic signed [TW-1:0]             ylen_cur;
	logic signed [TW-1:0]             ylen_prev;
	logic [dasd_pkg::DAY_W-1:0]       mlen_cur;
	logic signed [TW-1:0]             mlen_t;
	logic [dasd_pkg::DAY_W-1:0]       slen;

	// cycle position neighbors and leap flags
	assign mod_inc   = (mod_q == CYCLE_LAST) ? '0 : mod_q + MW'(1);
	assign mod_dec   = (mod_q == '0) ? CYCLE_LAST : mod_q - MW'(1);
	assign leap_cur  = dasd_pkg::leap_of(mod_q[dasd_pkg::CYCLE_W-1:0]);
	assign leap_prev = dasd_pkg::leap_of(mod_dec[dasd_pkg::CYCLE_W-1:0]);
	assign ylen_cur  = leap_cur ? TW'(366) : TW'(365);
	assign ylen_prev = leap_prev ? TW'(366) : TW'(365);
	assign mlen_cur  = dasd_pkg::month_len(mo_q, leap_cur);
	assign mlen_t    = TW'(mlen_cur);
	assign slen      = dasd_pkg::month_len(smon_q, leap_cur);

	// status toward the controller
	always_comb begin
		stat.mod_ge_cycle = (mod_q >= CYCLE);
		stat.date_bad     = (smon_q < dasd_pkg::MONTH_JAN) || (smon_q > dasd_pkg::MONTH_DEC)
			|| (YW'(syear_q) > YEAR_LAST) || (sday_q == '0) || (sday_q > slen);
		stat.doy_more     = (mo_q < smon_q);
		stat.year_more    = sub_q ? (t_q < 0) : (t_q >= ylen_cur);
		stat.year_err     = stat.year_more && (sub_q ? (ry_q == '0) : (ry_q == YEAR_LAST));
		stat.month_more   = (mo_q < dasd_pkg::MONTH_DEC) && (t_q >= mlen_t);
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sub_q   <= req_type;
			sday_q  <= start_day;
			smon_q  <= start_month;
			syear_q <= start_year;
			off_q   <= offset_days;
			ry_q    <= YW'(start_year);
			mod_q   <= start_year;
			mo_q    <= dasd_pkg::MONTH_JAN;
			t_q     <= TW'(start_day) - TW'(1);
			st_q    <= dasd_pkg::STATUS_OK;
		end
		// reduce the start year to its place in the leap cycle
		if (cmd.mod_step) begin
			mod_q <= mod_q - CYCLE;
		end
		if (cmd.flag_invalid) begin
			st_q <= dasd_pkg::STATUS_BAD_DATE;
		end
		if (cmd.flag_range) begin
			st_q <= dasd_pkg::STATUS_RANGE;
		end
		// day of year of the start date
		if (cmd.doy_step) begin
			t_q  <= t_q + mlen_t;
			mo_q <= mo_q + dasd_pkg::MONTH_W'(1);
		end
		// move the day index by the offset
		if (cmd.apply) begin
			if (sub_q) begin
				t_q <= t_q - $signed({2'b00, off_q});
			end else begin
				t_q <= t_q + $signed({2'b00, off_q});
			end
		end
		// one whole year per beat of the walk
		if (cmd.year_step) begin
			if (sub_q) begin
				t_q   <= t_q + ylen_prev;
				ry_q  <= ry_q - YW'(1);
				mod_q <= mod_dec;
			end else begin
				t_q   <= t_q - ylen_cur;
				ry_q  <= ry_q + YW'(1);
				mod_q <= mod_inc;
			end
		end
		if (cmd.month_init) begin
			mo_q <= dasd_pkg::MONTH_JAN;
		end
		// one month per step within the result year
		if (cmd.month_step) begin
			t_q  <= t_q - mlen_t;
			mo_q <= mo_q + dasd_pkg::MONTH_W'(1);
		end
		// result register, echoing the start date on failure
		if (cmd.publish) begin
			res_st_q <= st_q;
			if (st_q == dasd_pkg::STATUS_OK) begin
				res_day_q  <= t_q[dasd_pkg::DAY_W-1:0] + dasd_pkg::DAY_W'(1);
				res_mon_q  <= mo_q;
				res_year_q <= ry_q[dasd_pkg::YEAR_IN_W-1:0];
			end else begin
				res_day_q  <= sday_q;
				res_mon_q  <= smon_q;
				res_year_q <= syear_q;
			end
		end
	end

	assign result_day   = res_day_q;
	assign result_month = res_mon_q;
	assign result_year  = res_year_q;
	assign status       = res_st_q;
endmodule

/* hw/rtl/dasd_ctrl.sv */
// controller: sequences the datapath and owns both handshakes
module dasd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dasd_pkg::stat_t stat,
	output dasd_pkg::cmd_t  cmd
);
	dasd_pkg::state_t state_q;
	dasd_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == dasd_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dasd_pkg::ST_IDLE: begin
				if (in_valid) state_d = dasd_pkg::ST_MOD;
			end
			dasd_pkg::ST_MOD: begin
				if (!stat.mod_ge_cycle) state_d = dasd_pkg::ST_CHECK;
			end
			dasd_pkg::ST_CHECK: begin
				state_d = stat.date_bad ? dasd_pkg::ST_FINISH : dasd_pkg::ST_DOY;
			end
			dasd_pkg::ST_DOY: begin
				if (!stat.doy_more) state_d = dasd_pkg::ST_APPLY;
			end
			dasd_pkg::ST_APPLY: begin
				state_d = dasd_pkg::ST_YEAR;
			end
			dasd_pkg::ST_YEAR: begin
				if (stat.year_err) state_d = dasd_pkg::ST_FINISH;
				else if (!stat.year_more) state_d = dasd_pkg::ST_MONTH;
			end
			dasd_pkg::ST_MONTH: begin
				if (!stat.month_more) state_d = dasd_pkg::ST_FINISH;
			end
			dasd_pkg::ST_FINISH: begin
				if (out_free) state_d = dasd_pkg::ST_IDLE;
			end
			default: state_d = dasd_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			dasd_pkg::ST_IDLE:   cmd.load = in_valid;
			dasd_pkg::ST_MOD:    cmd.mod_step = stat.mod_ge_cycle;
			dasd_pkg::ST_CHECK:  cmd.flag_invalid = stat.date_bad;
			dasd_pkg::ST_DOY:    cmd.doy_step = stat.doy_more;
			dasd_pkg::ST_APPLY:  cmd.apply = 1'b1;
			dasd_pkg::ST_YEAR: begin
				cmd.flag_range = stat.year_err;
				cmd.year_step  = stat.year_more && !stat.year_err;
				cmd.month_init = !stat.year_more;
			end
			dasd_pkg::ST_MONTH:  cmd.month_step = stat.month_more;
			dasd_pkg::ST_FINISH: cmd.publish = out_free;
			default: cmd = '0;
		endcase
	end

	// state and result valid flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dasd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

/* hw/rtl/date_add_subtract_days.sv */
// top level: gregorian date plus or minus a number of days
//
// Each request beat carries a start date, a day offset and a direction; one response beat
// returns the resulting date with a status (ok, invalid start date, result outside year 0 to
// YEAR_MAX, the last two echoing the start date). One request is worked at a time: the controller
// reduces the start year to its place in the 400 year leap cycle, checks the start date, counts
// its day of year, applies the offset, then walks the years, one whole year per cycle, and the
// months of the result year. A finished result sits in an output register, and the next request
// is taken while it waits to be read.
`include "assert_macros.svh"

module date_add_subtract_days #(
	parameter int YEAR_MAX    = dasd_pkg::YEAR_MAX_DEF,
	parameter int OFFSET_BITS = dasd_pkg::OFFSET_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	dasd_req_if.sink    req,
	dasd_rsp_if.source  rsp
);
	dasd_pkg::cmd_t  cmd;
	dasd_pkg::stat_t stat;
	logic            rsp_ok;
	logic            month_legal;

	// sequencing and handshakes
	dasd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// date arithmetic and result register
	dasd_datapath #(
		.YEAR_MAX    (YEAR_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req.req_type),
		.start_day    (req.start_day),
		.start_month  (req.start_month),
		.start_year   (req.start_year),
		.offset_days  (req.offset_days),
		.result_day   (rsp.result_day),
		.result_month (rsp.result_month),
		.result_year  (rsp.result_year),
		.status       (rsp.status)
	);

	// helpers for the checks below
	assign rsp_ok      = rsp.valid && (rsp.status == dasd_pkg::STATUS_OK);
	assign month_legal = (rsp.result_month >= dasd_pkg::MONTH_JAN)
		&& (rsp.result_month <= dasd_pkg::MONTH_DEC);

	// a request beat closes the request side until its result is published
	`DASD_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	// a good result names a real month and a day in it
	`DASD_ASSERT_IMPL(a_ok_date_sane, rsp_ok, month_legal && (rsp.result_day != '0))
	// february never goes past the leap day
	`DASD_ASSERT_IMPL(a_feb_bound, rsp_ok && rsp.result_month == dasd_pkg::MONTH_FEB, rsp.result_day <= 5'd29)
	// status never carries the unused code
	`DASD_ASSERT(a_status_code, !rsp.valid || rsp.status <= dasd_pkg::STATUS_RANGE)
endmodule
